// ----- sv/msha1_pkg.sv -----
// ----------------------------------------------------------------------------
// msha1_pkg
// Shared types and constants of the modified sha-1 hash unit.
// ----------------------------------------------------------------------------
package msha1_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned C_CMD_DEPTH = 4;
    localparam int unsigned C_RES_DEPTH = 2;
    localparam int unsigned C_COUNT_W   = 61;

    localparam t_word C_IV [5] = '{
        32'h32075416, 32'hF8DAE9BC, 32'h73541260, 32'h8ACB9DFE, 32'hFD0C2E1B
    };

    localparam t_word C_K_CH  = 32'h5D6AA4D4;
    localparam t_word C_K_PAR = 32'h16AE9DEB;
    localparam t_word C_K_MAJ = 32'h34032E48;
    localparam t_word C_K_XOR = 32'h5CD39E93;

    localparam logic [7:0] C_PAD_BYTE  = 8'h80;
    localparam logic [5:0] C_PAD_LIMIT = 6'd56;
    localparam logic [5:0] C_BLOCK_END = 6'd63;
    localparam logic [2:0] C_LAST_WORD = 3'd4;

    typedef struct packed {
        logic       has_byte;
        logic       is_end;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_res;

endpackage

// ----- sv/msha1_fifo.sv -----
// ----------------------------------------------------------------------------
// msha1_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module msha1_fifo #(
    parameter int unsigned P_WIDTH = 8,
    parameter int unsigned P_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [P_WIDTH-1:0] o_data
);

    localparam int unsigned LP_AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned LP_CW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [LP_AW-1:0]   r_wr;
    logic [LP_AW-1:0]   r_rd;
    logic [LP_CW-1:0]   r_cnt;
    logic               push_ok;
    logic               pop_ok;

    assign o_full  = (r_cnt == LP_CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == LP_AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == LP_AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/msha1_front.sv -----
// ----------------------------------------------------------------------------
// msha1_front
// Takes requests, drops idle ones and queues byte and end commands.
// ----------------------------------------------------------------------------
module msha1_front #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_valid,
    input  logic              i_end_of_message,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output logic              o_cmd_empty,
    output msha1_pkg::t_cmd   o_cmd
);

    import msha1_pkg::*;

    t_cmd cmd_in;
    logic cmd_push;

    assign cmd_in.has_byte = i_byte_valid;
    assign cmd_in.is_end   = i_end_of_message;
    assign cmd_in.data     = i_data_byte;

    // idle requests are taken but leave no trace
    assign cmd_push = i_push & (i_byte_valid | i_end_of_message);

    msha1_fifo #(
        .P_WIDTH ($bits(t_cmd)),
        .P_DEPTH (P_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_empty (o_cmd_empty),
        .o_data  (o_cmd)
    );

endmodule

// ----- sv/msha1_back.sv -----
// ----------------------------------------------------------------------------
// msha1_back
// Block gathering, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module msha1_back #(
    parameter int unsigned P_RES_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msha1_pkg::t_cmd   i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              o_res_empty,
    input  logic              i_res_pop,
    output msha1_pkg::t_word  o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_final_word
);

    import msha1_pkg::*;

    localparam logic [2:0] ST_ACC = 3'd0;
    localparam logic [2:0] ST_PAD = 3'd1;
    localparam logic [2:0] ST_LEN = 3'd2;
    localparam logic [2:0] ST_RND = 3'd3;
    localparam logic [2:0] ST_FF  = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_PADMID = 2'd2;
    localparam logic [1:0] MODE_FINAL  = 2'd3;

    localparam logic [6:0] RND_PAR  = 7'd20;
    localparam logic [6:0] RND_MAJ  = 7'd40;
    localparam logic [6:0] RND_XOR  = 7'd61;
    localparam logic [6:0] RND_LAST = 7'd79;

    logic [2:0]           r_state;
    logic [1:0]           r_mode;
    logic [5:0]           r_pos;
    logic [C_COUNT_W-1:0] r_count;
    logic                 r_pad_first;
    logic [2:0]           r_len_k;
    logic [6:0]           r_rnd;
    logic [2:0]           r_word_k;
    t_word                r_chain [5];
    t_word                r_w [16];
    t_word                r_a, r_b, r_c, r_d, r_e;
    logic [7:0]           r_byte0;

    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    t_word       f_val;
    t_word       t_val;
    t_word       w_new;
    t_word       w_sum;
    logic        res_push;
    logic        res_full;
    logic        res_ok;
    t_res        res_in;
    t_res        res_out;

    assign bit_len  = {r_count, 3'b000};
    assign len_byte = bit_len[{~r_len_k, 3'b000} +: 8];

    assign o_cmd_pop = (r_state == ST_ACC);

    always_comb begin
        shift_en   = 1'b0;
        shift_byte = i_cmd.data;
        unique case (r_state)
            ST_ACC: begin
                shift_en   = ~i_cmd_empty & i_cmd.has_byte;
                shift_byte = i_cmd.data;
            end
            ST_PAD: begin
                shift_en   = 1'b1;
                shift_byte = r_pad_first ? C_PAD_BYTE : 8'h00;
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                shift_byte = len_byte;
            end
            default: begin
                shift_en   = 1'b0;
                shift_byte = i_cmd.data;
            end
        endcase
    end

    // round function
    always_comb begin
        priority if (r_rnd < RND_PAR) begin
            f_val = ((r_b & r_c) | (r_d & ~r_b)) - C_K_CH;
        end else if (r_rnd < RND_MAJ) begin
            f_val = (r_b ^ r_c ^ r_d) + C_K_PAR + {24'd0, r_byte0};
        end else if (r_rnd < RND_XOR) begin
            f_val = ((r_b & r_c) | (r_b & r_d) | (r_c & r_d)) - C_K_MAJ;
        end else begin
            f_val = (r_b ^ r_c ^ r_d) - C_K_XOR;
        end
    end

    assign t_val = f_val + {r_a[26:0], r_a[31:27]} + r_e + r_w[0];
    assign w_sum = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_sum[30:0], w_sum[31]};

    // message window and working variables
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= {r_w[j][23:0], r_w[j+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], shift_byte};
        end else if (r_state == ST_RND) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_new;
        end
        if (shift_en && r_pos == 6'd0) begin
            r_byte0 <= shift_byte;
        end
        if (r_state == ST_RND) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_mode      <= MODE_NORMAL;
            r_pos       <= '0;
            r_count     <= '0;
            r_pad_first <= 1'b0;
            r_len_k     <= '0;
            r_rnd       <= '0;
            r_word_k    <= '0;
            r_chain     <= C_IV;
        end else begin
            unique case (r_state)
                ST_ACC: begin
                    if (!i_cmd_empty) begin
                        if (i_cmd.has_byte) begin
                            r_pos   <= r_pos + 1'b1;
                            r_count <= r_count + 1'b1;
                        end
                        if (i_cmd.has_byte && r_pos == C_BLOCK_END) begin
                            r_state <= ST_RND;
                            r_rnd   <= '0;
                            r_mode  <= i_cmd.is_end ? MODE_END : MODE_NORMAL;
                        end else if (i_cmd.is_end) begin
                            r_state     <= ST_PAD;
                            r_pad_first <= 1'b1;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_first <= 1'b0;
                    r_pos       <= r_pos + 1'b1;
                    if (r_pos == C_BLOCK_END) begin
                        r_state <= ST_RND;
                        r_rnd   <= '0;
                        r_mode  <= MODE_PADMID;
                    end else if (r_pos == C_PAD_LIMIT - 6'd1) begin
                        r_state <= ST_LEN;
                        r_len_k <= '0;
                    end
                end
                ST_LEN: begin
                    r_pos   <= r_pos + 1'b1;
                    r_len_k <= r_len_k + 1'b1;
                    if (r_len_k == 3'd7) begin
                        r_state <= ST_RND;
                        r_rnd   <= '0;
                        r_mode  <= MODE_FINAL;
                    end
                end
                ST_RND: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == RND_LAST) begin
                        r_state <= ST_FF;
                    end
                end
                ST_FF: begin
                    r_chain[0] <= r_chain[0] + r_a + 32'd1;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    unique case (r_mode)
                        MODE_NORMAL: r_state <= ST_ACC;
                        MODE_END: begin
                            r_state     <= ST_PAD;
                            r_pad_first <= 1'b1;
                        end
                        MODE_PADMID: r_state <= ST_PAD;
                        MODE_FINAL: begin
                            r_state  <= ST_OUT;
                            r_word_k <= '0;
                        end
                        default: r_state <= ST_ACC;
                    endcase
                end
                ST_OUT: begin
                    if (res_ok) begin
                        r_word_k <= r_word_k + 1'b1;
                        if (r_word_k == C_LAST_WORD) begin
                            r_state <= ST_ACC;
                            r_chain <= C_IV;
                            r_count <= '0;
                            r_pos   <= '0;
                        end
                    end
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

    assign res_push     = (r_state == ST_OUT);
    assign res_ok       = res_push & ~res_full;
    assign res_in.word  = r_chain[r_word_k];
    assign res_in.index = r_word_k;
    assign res_in.last  = (r_word_k == C_LAST_WORD);

    msha1_fifo #(
        .P_WIDTH ($bits(t_res)),
        .P_DEPTH (P_RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_empty (o_res_empty),
        .o_data  (res_out)
    );

    assign o_digest_word = res_out.word;
    assign o_word_index  = res_out.index;
    assign o_final_word  = res_out.last;

    a_pos_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_pos == r_count[5:0]))
        else $error("block position out of step with byte count");

    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_pos[5:3] == 3'b111 && r_pos[2:0] == r_len_k))
        else $error("length bytes not at block tail");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND) |-> (r_rnd <= RND_LAST))
        else $error("round counter past last round");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_ok && r_word_k == C_LAST_WORD) |=> (r_state == ST_ACC && r_count == '0))
        else $error("no re-initialization after last digest word");

endmodule

// ----- sv/modified_sha1_hash_unit.sv -----
// ----------------------------------------------------------------------------
// modified_sha1_hash_unit
// Hashes a byte stream with an altered sha-1 and returns five digest words.
// ----------------------------------------------------------------------------
// Requests enter a command queue at up to one per cycle while it is not full;
// idle requests are dropped there. The back end absorbs one message byte per
// cycle while gathering a block and runs each full 64-byte block through a
// single shared round unit and then a feed-forward step, taking no new bytes
// meanwhile. An end of message adds up to 72 padding and length bytes, one or
// two compressions, and five digest words pushed into a small result queue as
// it has room.
module modified_sha1_hash_unit #(
    parameter int unsigned P_CMD_DEPTH = msha1_pkg::C_CMD_DEPTH,
    parameter int unsigned P_RES_DEPTH = msha1_pkg::C_RES_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);

    import msha1_pkg::*;

    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;

    msha1_front #(
        .P_DEPTH (P_CMD_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_full           (full),
        .i_cmd_pop        (cmd_pop),
        .o_cmd_empty      (cmd_empty),
        .o_cmd            (cmd)
    );

    msha1_back #(
        .P_RES_DEPTH (P_RES_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_empty   (cmd_empty),
        .o_cmd_pop     (cmd_pop),
        .o_res_empty   (empty),
        .i_res_pop     (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word)
    );

endmodule

// ----- test/modified_sha1_hash_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modified_sha1_hash_unit_test
// Self-checking bench for the altered sha-1 hash unit. Byte requests go in
// through the push/full side, and digest words come out through the pop/empty
// side. A cycle-free software copy of the hash predicts five words for each
// end of message, and each popped word is checked against the oldest
// prediction. A short stimulus table comes first. Random messages follow,
// with boundary lengths, stray requests and idle requests mixed in. The sender
// and the receiver run with several idle and stall mixes, and one long
// receiver hold-off fills the unit.
// ----------------------------------------------------------------------------
module modified_sha1_hash_unit_test;

    import msha1_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES  = 1000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eom;
    } t_row;

    // directed requests, all checked against the predictor
    localparam t_row DIRECTED [18] = '{
        '{8'h00, 1'b0, 1'b1},   // empty message straight after reset
        '{8'hA5, 1'b0, 1'b0},   // idle request
        '{8'h00, 1'b1, 1'b1},   // single zero byte with end
        '{8'hFF, 1'b1, 1'b1},   // single ff byte with end
        '{8'h00, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b0},
        '{8'h5A, 1'b0, 1'b0},   // idle inside a message
        '{8'h80, 1'b1, 1'b0},
        '{8'h01, 1'b0, 1'b1},   // empty end after three bytes
        '{8'hFE, 1'b0, 1'b1},   // empty message, junk data
        '{8'h7F, 1'b1, 1'b0},
        '{8'h80, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b1},
        '{8'h00, 1'b0, 1'b0},
        '{8'hC3, 1'b1, 1'b0},
        '{8'h3C, 1'b0, 1'b1},
        '{8'h55, 1'b1, 1'b0},
        '{8'hAA, 1'b1, 1'b1}
    };

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        push             = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_byte_valid     = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_final_word;

    // predictor state
    t_word          chain_st [5];
    logic [7:0]     blk_bytes [64];
    logic [60:0]    msg_bytes;
    t_res           digest_q [$];
    t_res           head_res;

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned req_count     = 0;
    int unsigned msg_count     = 0;
    int unsigned words_checked = 0;
    int unsigned full_stalls   = 0;
    int unsigned tx_gap_pct    = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned hold_left     = 0;
    bit          hold_req      = 1'b0;

    modified_sha1_hash_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_final_word     (o_final_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_hash_state();
        for (int k = 0; k < 5; k++) chain_st[k] = C_IV[k];
        for (int k = 0; k < 64; k++) blk_bytes[k] = 8'h00;
        msg_bytes = '0;
    endfunction

    function automatic void compress_block();
        t_word w [80];
        t_word a, b, c, d, e, f, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        e = chain_st[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = ((b & c) | (d & ~b)) - C_K_CH;
            end else if (i < 40) begin
                f = (b ^ c ^ d) + C_K_PAR + {24'd0, blk_bytes[0]};
            end else if (i < 61) begin
                f = ((b & c) | (b & d) | (c & d)) - C_K_MAJ;
            end else begin
                f = (b ^ c ^ d) - C_K_XOR;
            end
            t = f + {a[26:0], a[31:27]} + e + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_st[0] += a + 32'd1;
        chain_st[1] += b;
        chain_st[2] += c;
        chain_st[3] += d;
        chain_st[4] += e;
    endfunction

    // absorbs one accepted request and queues the digest words it causes
    function automatic void hash_request(logic [7:0] data, logic valid, logic eom);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        t_res        r;
        if (valid) begin
            pos = msg_bytes[5:0];
            blk_bytes[pos] = data;
            msg_bytes = msg_bytes + 61'd1;
            if (pos == C_BLOCK_END) compress_block();
        end
        if (!eom) return;
        pos = msg_bytes[5:0];
        for (int k = pos; k < 64; k++) blk_bytes[k] = 8'h00;
        blk_bytes[pos] = C_PAD_BYTE;
        if (pos >= C_PAD_LIMIT) begin
            compress_block();
            for (int k = 0; k < 64; k++) blk_bytes[k] = 8'h00;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int k = 0; k < 8; k++) blk_bytes[56+k] = bit_len[63-8*k -: 8];
        compress_block();
        for (int k = 0; k < 5; k++) begin
            r.word  = chain_st[k];
            r.index = 3'(k);
            r.last  = (3'(k) == C_LAST_WORD);
            digest_q.push_back(r);
        end
        clear_hash_state();
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(input logic [7:0] data, input logic valid, input logic eom);
        while ($urandom_range(99) < tx_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_data_byte      <= data;
        i_byte_valid     <= valid;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        hash_request(data, valid, eom);
        if (valid || eom) req_count++;
    endtask

    task automatic send_message(input int len, input bit noisy);
        bit joined;
        joined = (len > 0) && ($urandom_range(1) == 1);
        for (int n = 0; n < len; n++) begin
            if (noisy && $urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, joined && (n == len - 1));
        end
        if (!joined) send_request(8'($urandom), 1'b0, 1'b1);
        msg_count++;
    endtask

    function automatic int pick_len();
        int edge_lens [8] = '{0, 1, 55, 56, 57, 63, 64, 65};
        if ($urandom_range(4) == 0) return edge_lens[$urandom_range(7)];
        return $urandom_range(12);
    endfunction

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input int unsigned n_req);
        int unsigned req0, msg0;
        tx_gap_pct   = gap;
        rx_stall_pct = stall;
        req0 = req_count;
        msg0 = msg_count;
        while (req_count - req0 < n_req || msg_count - msg0 < 3) begin
            if ($urandom_range(9) == 0) begin
                // stray request between messages, may add a byte or an end of message
                send_request(8'($urandom), 1'($urandom_range(1)), $urandom_range(3) == 0);
            end else begin
                send_message(pick_len(), 1'b1);
            end
        end
    endtask

    // receiver
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (digest_q.size() == 0) begin
                report_error($sformatf("unexpected digest word 0x%08h index %0d",
                                       o_digest_word, o_word_index));
            end else begin
                head_res = digest_q.pop_front();
                if (o_digest_word !== head_res.word)
                    report_error($sformatf("word %0d: digest 0x%08h, predicted 0x%08h",
                                           head_res.index, o_digest_word, head_res.word));
                if (o_word_index !== head_res.index)
                    report_error($sformatf("word index %0d, predicted %0d",
                                           o_word_index, head_res.index));
                if (o_final_word !== head_res.last)
                    report_error($sformatf("word %0d: final flag %0b, predicted %0b",
                                           head_res.index, o_final_word, head_res.last));
                words_checked++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("modified_sha1_hash_unit verification failed");
            $finish;
        end
    end

    initial begin
        clear_hash_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) send_request(DIRECTED[k].data, DIRECTED[k].valid, DIRECTED[k].eom);

        run_phase(0, 0, 25);
        run_phase(88, 0, 25);
        run_phase(0, 88, 25);
        run_phase(38, 38, 25);

        // long receiver hold-off while short messages keep coming
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        repeat (6) send_message(2, 1'b0);
        push <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d messages, %0d digest words checked",
                 req_count, msg_count, words_checked);
        $display("input held off by a full unit for %0d cycles", full_stalls);
        if (error_count == 0) begin
            $display("modified_sha1_hash_unit verification clean");
        end else begin
            $display("modified_sha1_hash_unit verification failed");
        end
        $finish;
    end

endmodule
